// ----- hdl/bec_pkg.sv -----
// ----------------------------------------------------------------------------
// bec_pkg
// Shared character codes and the translator result type for the
// backslash escape codec.
// ----------------------------------------------------------------------------
package bec_pkg;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_N   = 8'h6E;
    localparam logic [7:0] CH_R   = 8'h72;
    localparam logic [7:0] CH_T   = 8'h74;

    // What one input item turns into: up to two output bytes and the
    // pending-backslash state that it leaves behind.
    typedef struct packed {
        logic       has_first;
        logic       has_second;
        logic [7:0] first_byte;
        logic       first_last;
        logic       first_end;
        logic [7:0] second_byte;
        logic       second_last;
        logic       pending_next;
    } xlat_t;

endpackage

// ----- hdl/bec_xlat.sv -----
// ----------------------------------------------------------------------------
// bec_xlat
// Combinational translator: maps one held input byte to its output bytes
// in escape or unescape mode.
// ----------------------------------------------------------------------------
module bec_xlat
(
    input  logic           decode_mode,
    input  logic           pending,
    input  logic [7:0]     in_byte,
    input  logic           in_last,
    output bec_pkg::xlat_t res
);

    logic [7:0] esc_code;
    logic       esc_hit;
    logic [7:0] unesc_code;

    always_comb
    begin
        esc_hit  = 1'b1;
        esc_code = in_byte;
        case (in_byte)
            bec_pkg::CH_BSL: esc_code = bec_pkg::CH_BSL;
            bec_pkg::CH_TAB: esc_code = bec_pkg::CH_T;
            bec_pkg::CH_CR:  esc_code = bec_pkg::CH_R;
            bec_pkg::CH_LF:  esc_code = bec_pkg::CH_N;
            default:         esc_hit  = 1'b0;
        endcase
    end

    always_comb
    begin
        case (in_byte)
            bec_pkg::CH_N: unesc_code = bec_pkg::CH_LF;
            bec_pkg::CH_R: unesc_code = bec_pkg::CH_CR;
            bec_pkg::CH_T: unesc_code = bec_pkg::CH_TAB;
            default:       unesc_code = in_byte;
        endcase
    end

    always_comb
    begin
        res              = '0;
        res.has_first    = 1'b1;
        res.first_byte   = in_byte;
        res.first_last   = in_last;
        res.first_end    = 1'b1;
        res.second_byte  = esc_code;
        res.second_last  = in_last;
        res.pending_next = 1'b0;
        if (!decode_mode)
        begin
            if (esc_hit)
            begin
                // emit backslash first, the escape letter second
                res.has_second = 1'b1;
                res.first_byte = bec_pkg::CH_BSL;
                res.first_last = 1'b0;
                res.first_end  = 1'b0;
            end
        end
        else if (pending)
        begin
            res.first_byte = unesc_code;
        end
        else if ((in_byte == bec_pkg::CH_BSL) && !in_last)
        begin
            // hold the backslash until the next byte resolves it
            res.has_first    = 1'b0;
            res.pending_next = 1'b1;
        end
    end

endmodule

// ----- hdl/bec_out_stage.sv -----
// ----------------------------------------------------------------------------
// bec_out_stage
// Output register with a second slot for the tail byte of a two-byte escape.
// ----------------------------------------------------------------------------
module bec_out_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  bec_pkg::xlat_t res,
    output logic           free,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           out_last,
    output logic           run_end
);

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       run_end_reg;
    logic       second_valid_reg;
    logic [7:0] second_byte_reg;
    logic       second_last_reg;
    logic       out_fire;

    assign out_fire = out_valid_reg && out_ready;
    // empty after this edge, so a new item may load
    assign free     = !out_valid_reg || (out_ready && !second_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            second_valid_reg <= 1'b0;
        end
        else if (load && res.has_first)
        begin
            out_valid_reg    <= 1'b1;
            second_valid_reg <= res.has_second;
        end
        else if (out_fire)
        begin
            out_valid_reg    <= second_valid_reg;
            second_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res.has_first)
        begin
            out_byte_reg    <= res.first_byte;
            out_last_reg    <= res.first_last;
            run_end_reg     <= res.first_end;
            second_byte_reg <= res.second_byte;
            second_last_reg <= res.second_last;
        end
        else if (out_fire && second_valid_reg)
        begin
            out_byte_reg <= second_byte_reg;
            out_last_reg <= second_last_reg;
            run_end_reg  <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign run_end   = run_end_reg;

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        second_valid_reg |-> out_valid_reg)
        else $error("second slot held without a first");

    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        (load && res.has_first) |-> free)
        else $error("load into a busy output stage");

    a_second_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && second_valid_reg) |=> (out_valid_reg && run_end_reg))
        else $error("tail byte did not close its run");

endmodule

// ----- hdl/backslash_escape_codec.sv -----
// ----------------------------------------------------------------------------
// backslash_escape_codec
// Backslash escape / unescape codec for a byte stream with end-of-string
// marks; mode selected by a one-bit configuration register.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ------------------------------
//  in        sink       in_valid/in_ready    in_byte[7:0], in_last
//  out       source     out_valid/out_ready  out_byte[7:0], out_last, run_end
//  cfg       sink       cfg_valid/cfg_ready  cfg_data (decode_mode)
//
//  Flow: an item is held in the input register, is translated and lands
//  in the output register; one byte per cycle sustained while out_ready
//  stays high, but an item that escapes into two bytes holds the output
//  register until it drains the tail byte from its second slot.
//  Reset: asynchronous, active low; clears mode to escape and drops any
//  pending backslash. Stalls: out_ready low holds both stages; a backslash
//  absorbed in unescape mode leaves the input register without output.
//
module backslash_escape_codec
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       run_end,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    logic           decode_mode_reg;
    logic           pending_reg;
    logic           s1_valid_reg;
    logic [7:0]     s1_byte_reg;
    logic           s1_last_reg;
    logic           s1_move;
    logic           out_free;
    logic           cfg_fire;
    bec_pkg::xlat_t res;

    // Register writes are taken at any time.
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // Advance the held item when it makes no output or the output stage
    // will be empty.
    assign s1_move  = s1_valid_reg && (!res.has_first || out_free);
    assign in_ready = !s1_valid_reg || s1_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_mode_reg <= 1'b0;
            pending_reg     <= 1'b0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                // a mode write abandons any waiting backslash
                decode_mode_reg <= cfg_data;
                pending_reg     <= 1'b0;
            end
            else if (s1_move)
            begin
                pending_reg <= res.pending_next;
            end
            if (in_valid && in_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= in_byte;
            s1_last_reg <= in_last;
        end
    end

    bec_xlat u_xlat
    (
        .decode_mode (decode_mode_reg),
        .pending     (pending_reg),
        .in_byte     (s1_byte_reg),
        .in_last     (s1_last_reg),
        .res         (res)
    );

    bec_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_move),
        .res       (res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .run_end   (run_end)
    );

    a_pending_only_unescape: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> decode_mode_reg)
        else $error("backslash pending in escape mode");

    a_cfg_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> !pending_reg)
        else $error("mode write left a backslash pending");

    a_pending_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && !cfg_fire && res.pending_next) |=> (pending_reg && !s1_valid_reg)
            || (pending_reg && s1_valid_reg))
        else $error("absorbed backslash not held");

endmodule

// ----- dv/backslash_escape_codec_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// backslash_escape_codec_tb
// Self-checking bench for the backslash escape codec. A queue-fed driver
// offers characters in bursts, and a receiver applies its own stall
// pattern. A monitor runs a cycle-free model of the codec on every accepted
// character and compares each converted byte, field by field, in order.
// The mode register is rewritten between phases, only while the codec is
// idle.
// ----------------------------------------------------------------------------
module backslash_escape_codec_tb;

    // Period 4 ns. Worst case is about 1400 items at two results each,
    // under heavy stalls and gaps, all within TIMEOUT_NS.
    localparam int  RESET_CYCLES = 12;
    localparam int  DRAIN_CYCLES = 8;     // input reg + output reg, with margin
    localparam int  HOLD_CYCLES  = 250;   // long receiver hold-off
    localparam int  PHASE_CHARS  = 220;
    localparam int  NUM_PHASES   = 6;
    localparam int  END_WAIT     = 5000;
    localparam real TIMEOUT_NS   = 2_000_000.0;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       fin;
    } coded_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte   = 8'h00;
    logic       in_last   = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       out_last;
    logic       run_end;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data  = 1'b0;

    // Characters waiting to be driven, and converted bytes still owed.
    char_t  tx_chars[$];
    coded_t coded_q[$];

    // Model state: current mode and the held backslash of unescape mode.
    logic mode_decode = 1'b0;
    logic bsl_held    = 1'b0;

    // Sender burst shaping and receiver stall shaping.
    int   burst_left = 1;
    int   gap_left   = 0;
    logic tx_steady  = 1'b0;
    logic rx_hold    = 1'b0;
    logic [7:0] rx_pattern = 8'hFF;
    int   rx_seg     = 0;

    int chars_queued = 0;
    int strings_sent = 0;
    int in_count     = 0;
    int out_count    = 0;
    int cfg_writes   = 0;
    int err_count    = 0;

    backslash_escape_codec dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .run_end   (run_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %02h want %02h (result %0d)",
                 $realtime, what, got, want, out_count);
        err_count++;
    endtask

    function automatic void push_char(input logic [7:0] c, input logic l);
        tx_chars.push_back({c, l});
        chars_queued++;
        if (l)
            strings_sent++;
    endfunction

    // Work out the converted bytes for one accepted character and append
    // them to the store of bytes still owed.
    function automatic void translate_char(input logic [7:0] ch, input logic last);
        logic [7:0] code;
        logic       pair;
        code = ch;
        pair = 1'b1;
        if (!mode_decode)
        begin
            case (ch)
                bec_pkg::CH_BSL: code = bec_pkg::CH_BSL;
                bec_pkg::CH_TAB: code = bec_pkg::CH_T;
                bec_pkg::CH_CR:  code = bec_pkg::CH_R;
                bec_pkg::CH_LF:  code = bec_pkg::CH_N;
                default:         pair = 1'b0;
            endcase
            if (pair)
            begin
                coded_q.push_back({bec_pkg::CH_BSL, 1'b0, 1'b0});
                coded_q.push_back({code, last, 1'b1});
            end
            else
            begin
                coded_q.push_back({ch, last, 1'b1});
            end
        end
        else if (bsl_held)
        begin
            // Resolve the held backslash; unknown escapes drop it.
            bsl_held = 1'b0;
            case (ch)
                bec_pkg::CH_N: code = bec_pkg::CH_LF;
                bec_pkg::CH_R: code = bec_pkg::CH_CR;
                bec_pkg::CH_T: code = bec_pkg::CH_TAB;
                default:       code = ch;
            endcase
            coded_q.push_back({code, last, 1'b1});
        end
        else if (ch == bec_pkg::CH_BSL && !last)
        begin
            // Absorb the backslash; nothing comes out yet.
            bsl_held = 1'b1;
        end
        else
        begin
            coded_q.push_back({ch, last, 1'b1});
        end
    endfunction

    // Wait until every queued character is taken and nothing is owed, then
    // give an absorbed backslash time to leave the pipeline.
    task automatic settle();
        while (in_count != chars_queued || coded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        settle();
        cfg_data  <= m;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Driver: hold an offered item until taken, otherwise send from the
    // queue in bursts, with random gaps between bursts.
    always @(posedge clk or negedge rst_n)
    begin : sender
        char_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= 8'h00;
            in_last  <= 1'b0;
        end
        else if (in_valid && !in_ready)
        begin
            // hold: payload stays put until the handshake
        end
        else if (gap_left != 0)
        begin
            gap_left = gap_left - 1;
            in_valid <= 1'b0;
        end
        else if (tx_chars.size() != 0)
        begin
            nxt = tx_chars.pop_front();
            in_valid <= 1'b1;
            in_byte  <= nxt.ch;
            in_last  <= nxt.last;
            if (burst_left > 1)
            begin
                burst_left = burst_left - 1;
            end
            else
            begin
                burst_left = $urandom_range(1, 16);
                if (tx_steady || $urandom_range(0, 3) == 0)
                    gap_left = 0;
                else
                    gap_left = $urandom_range(1, 6);
            end
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // Receiver: rotate a stall pattern that is reloaded for each new segment;
    // some segments never stall. The hold-off process can force ready low.
    always @(posedge clk or negedge rst_n)
    begin : receiver
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            rx_pattern = 8'hFF;
            rx_seg     = 0;
        end
        else
        begin
            if (rx_seg == 0)
            begin
                rx_seg = 64;
                case ($urandom_range(0, 3))
                    0:       rx_pattern = 8'hFF;
                    1:       rx_pattern = 8'($urandom_range(0, 255));
                    2:       rx_pattern = 8'($urandom_range(0, 255) | $urandom_range(0, 255));
                    default: rx_pattern = 8'($urandom_range(0, 255) & $urandom_range(0, 255));
                endcase
            end
            rx_seg     = rx_seg - 1;
            rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
            out_ready <= rx_pattern[0] && !rx_hold;
        end
    end

    // Hold off the receiver for a long stretch twice, both times in unescape
    // mode, while the sender keeps offering, so the codec backs up to its input.
    initial
    begin : rx_holdoff
        wait (in_count >= 300);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
        wait (in_count >= 900);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Monitor: track config writes and accepted characters in the model,
    // and check every accepted result against the oldest owed byte.
    always @(posedge clk)
    begin : monitor
        coded_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                // Any mode write drops a held backslash.
                mode_decode = cfg_data;
                bsl_held    = 1'b0;
            end
            if (in_valid && in_ready)
            begin
                translate_char(in_byte, in_last);
                in_count++;
            end
            if (out_valid && out_ready)
            begin
                out_count++;
                if (coded_q.size() == 0)
                begin
                    report_mismatch("result with nothing owed", int'(out_byte), 0);
                end
                else
                begin
                    want = coded_q.pop_front();
                    if (out_byte !== want.ch)
                        report_mismatch("out_byte", int'(out_byte), int'(want.ch));
                    if (out_last !== want.last)
                        report_mismatch("out_last", int'(out_last), int'(want.last));
                    if (run_end !== want.fin)
                        report_mismatch("run_end", int'(run_end), int'(want.fin));
                end
            end
        end
    end

    initial
    begin : stimulus
        int         phase;
        int         target;
        int         len;
        int         k;
        int         waited;
        logic       decode;
        logic [7:0] c;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Escape mode: field extremes and each control character.
        write_mode(1'b0);
        push_char(8'h00, 1'b0);
        push_char(8'hFF, 1'b1);
        push_char(bec_pkg::CH_TAB, 1'b0);
        push_char(bec_pkg::CH_CR, 1'b0);
        push_char(bec_pkg::CH_LF, 1'b0);
        push_char(bec_pkg::CH_BSL, 1'b1);

        // Unescape mode: every resolved escape, an unknown escape that
        // drops its backslash, escapes of the byte extremes, a lone
        // trailing backslash, and a plain letter with nothing held.
        write_mode(1'b1);
        push_char(bec_pkg::CH_BSL, 1'b0); push_char(bec_pkg::CH_N, 1'b0);
        push_char(bec_pkg::CH_BSL, 1'b0); push_char(bec_pkg::CH_R, 1'b0);
        push_char(bec_pkg::CH_BSL, 1'b0); push_char(bec_pkg::CH_T, 1'b0);
        push_char(bec_pkg::CH_BSL, 1'b0); push_char(bec_pkg::CH_BSL, 1'b0);
        push_char(bec_pkg::CH_BSL, 1'b0); push_char("q", 1'b0);
        push_char(bec_pkg::CH_BSL, 1'b0); push_char(8'h00, 1'b0);
        push_char(bec_pkg::CH_BSL, 1'b0); push_char(8'hFF, 1'b1);
        push_char(bec_pkg::CH_BSL, 1'b1);
        push_char(bec_pkg::CH_N, 1'b1);

        // Leave a backslash held, rewrite the same mode: it must be
        // dropped so the next n passes through as a letter.
        push_char(bec_pkg::CH_BSL, 1'b0);
        write_mode(1'b1);
        push_char(bec_pkg::CH_N, 1'b1);

        // Leave a backslash held, then switch to escape mode.
        push_char(bec_pkg::CH_BSL, 1'b0);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            decode = phase[0];
            write_mode(decode);
            tx_steady = (phase == 2 || phase == 5);
            target = chars_queued + PHASE_CHARS;
            while (chars_queued < target)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    // Well-formed string with random content.
                    len = $urandom_range(1, 12);
                    for (k = 0; k < len; k++)
                    begin
                        if (!decode)
                        begin
                            case ($urandom_range(0, 7))
                                0:       c = bec_pkg::CH_BSL;
                                1:       c = bec_pkg::CH_TAB;
                                2:       c = bec_pkg::CH_CR;
                                3:       c = bec_pkg::CH_LF;
                                default: c = 8'($urandom_range(0, 255));
                            endcase
                            push_char(c, k == len - 1);
                        end
                        else if ($urandom_range(0, 2) == 0)
                        begin
                            case ($urandom_range(0, 4))
                                0:       c = bec_pkg::CH_N;
                                1:       c = bec_pkg::CH_R;
                                2:       c = bec_pkg::CH_T;
                                3:       c = bec_pkg::CH_BSL;
                                default: c = 8'($urandom_range(0, 255));
                            endcase
                            push_char(bec_pkg::CH_BSL, 1'b0);
                            push_char(c, k == len - 1);
                        end
                        else
                        begin
                            push_char(8'($urandom_range(32, 126)), k == len - 1);
                        end
                    end
                    // Now and then a lone trailing backslash as its own string.
                    if (decode && $urandom_range(0, 9) == 0)
                        push_char(bec_pkg::CH_BSL, 1'b1);
                end
                else
                begin
                    // Noise: raw bytes, heavy on backslashes, random ends.
                    len = $urandom_range(1, 16);
                    for (k = 0; k < len; k++)
                    begin
                        if ($urandom_range(0, 3) == 0)
                            c = bec_pkg::CH_BSL;
                        else
                            c = 8'($urandom_range(0, 255));
                        push_char(c, $urandom_range(0, 7) == 0);
                    end
                end
            end
        end

        // Drain: wait for every owed byte, bounded, then let the pipe empty.
        while (in_count != chars_queued)
            @(posedge clk);
        waited = 0;
        while (coded_q.size() != 0 && waited < END_WAIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (coded_q.size() != 0)
            report_mismatch("results never arrived", 0, coded_q.size());

        $display("Run: %0d characters in %0d strings, %0d converted bytes checked.",
                 in_count, strings_sent, out_count);
        $display("Mode register written %0d times, both modes, two long output stalls.",
                 cfg_writes);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
